[hw/rtl/pabl_pkg.sv]
`default_nettype none

package pabl_pkg;

  localparam int FracBits = 12;
  localparam int One      = 1 << FracBits;

  // port widths follow the fixed-point formats: Q3.F, Q1.F, Q0.F plus the whole-pixel code
  localparam int SyWidth    = FracBits + 4;
  localparam int SlopeWidth = FracBits + 2;
  localparam int CovWidth   = FracBits + 1;
  localparam int LimWidth   = FracBits + 1;

  // triangle height, its square, twice the slope magnitude, quotient
  localparam int HWidth   = FracBits + 1;
  localparam int NumWidth = 2 * FracBits + 1;
  localparam int DenWidth = SlopeWidth + 1;
  localparam int QWidth   = FracBits;

  // about 1.002 in Q1.F
  localparam logic [LimWidth-1:0] SteepLimitRst = LimWidth'(One + One / 512);

  typedef enum logic [1:0] {
    ErrNone  = 2'd0,
    ErrSteep = 2'd1,
    ErrGeom  = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    ModeDirect   = 2'd0,
    ModeTriBelow = 2'd1,
    ModeTriAbove = 2'd2
  } mode_e;

  typedef struct packed {
    logic                func;
    err_e                err;
    mode_e               mode;
    logic [CovWidth-1:0] direct;
  } tag_t;

  typedef struct packed {
    tag_t                tag;
    logic [NumWidth-1:0] rem;
    logic [DenWidth-1:0] den;
    logic [QWidth-1:0]   quot;
  } div_t;

  typedef struct packed {
    logic [CovWidth-1:0] coverage;
    err_e                err;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/pabl_if.sv]
`default_nettype none

interface pabl_req_if import pabl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [SyWidth-1:0]    start_y;
  logic signed [SlopeWidth-1:0] slope;

  modport source (output valid, output func, output start_y, output slope, input ready);
  modport sink   (input valid, input func, input start_y, input slope, output ready);
endinterface

interface pabl_res_if import pabl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CovWidth-1:0] coverage;
  logic [1:0]          error_code;

  modport source (output valid, output coverage, output error_code, input ready);
  modport sink   (input valid, input coverage, input error_code, output ready);
endinterface

`default_nettype wire

[hw/rtl/pabl_classify.sv]
`default_nettype none

module pabl_classify import pabl_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic                         func_i,
  input  logic signed [SyWidth-1:0]    start_y_i,
  input  logic signed [SlopeWidth-1:0] slope_i,
  input  logic [LimWidth-1:0]          steep_limit_i,
  output logic                         valid_o,
  output tag_t                         tag_o,
  output logic [HWidth-1:0]            h_o,
  output logic [DenWidth-1:0]          den_o
);

  localparam int EW = SyWidth + 1;

  logic signed [EW-1:0]     s_x, d_x, e_x, f_x, h_x, one_x;
  logic signed [EW:0]       sum_x;
  logic [SlopeWidth-1:0]    f_mag;
  logic                     steep;
  tag_t                     tag_d;
  logic [DenWidth-1:0]      den_d;

  logic                     valid_q;
  tag_t                     tag_q;
  logic [HWidth-1:0]        h_q;
  logic [DenWidth-1:0]      den_q;

  assign s_x   = EW'(start_y_i);
  assign d_x   = EW'(slope_i);
  assign e_x   = s_x + d_x;
  assign one_x = EW'(One);
  assign f_x   = (d_x < 0) ? -d_x : d_x;
  assign f_mag = f_x[SlopeWidth-1:0];
  assign steep = f_mag > SlopeWidth'(steep_limit_i);
  assign sum_x = (EW+1)'(s_x) + (EW+1)'(e_x);

  // divisor is twice the slope magnitude, never below one
  assign den_d = (f_mag == '0) ? DenWidth'(1) : {f_mag, 1'b0};

  always_comb begin
    tag_d.func   = func_i;
    tag_d.err    = ErrNone;
    tag_d.mode   = ModeDirect;
    tag_d.direct = '0;
    h_x          = '0;
    if (steep) begin
      tag_d.err = ErrSteep;
    end else if (s_x >= 0 && s_x <= one_x) begin
      if (e_x < 0) begin
        tag_d.mode = ModeTriBelow;
        h_x        = s_x;
      end else if (e_x > one_x) begin
        tag_d.mode = ModeTriAbove;
        h_x        = one_x - s_x;
      end else begin
        // trapezoid, mean of both edge heights
        tag_d.direct = sum_x[CovWidth:1];
      end
    end else if (s_x > one_x && e_x >= one_x) begin
      tag_d.direct = CovWidth'(One);
    end else if (s_x > one_x && e_x > 0 && e_x < one_x) begin
      tag_d.mode = ModeTriAbove;
      h_x        = one_x - e_x;
    end else if (s_x < 0 && e_x <= 0) begin
      tag_d.direct = '0;
    end else if (s_x < 0 && e_x > 0 && e_x < one_x) begin
      tag_d.mode = ModeTriBelow;
      h_x        = e_x;
    end else begin
      tag_d.err = ErrGeom;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q <= tag_d;
      h_q   <= h_x[HWidth-1:0];
      den_q <= den_d;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign h_o     = h_q;
  assign den_o   = den_q;

endmodule

`default_nettype wire

[hw/rtl/pabl_div_cell.sv]
`default_nettype none

module pabl_div_cell import pabl_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t dat_i,
  output logic valid_o,
  output div_t dat_o
);

  localparam int CmpW = DenWidth + QWidth;

  logic [CmpW-1:0] step, rem_x, diff;
  logic            take;
  div_t            dat_d;
  logic            valid_q;
  div_t            dat_q;

  // one restoring step: try the divisor shifted to this quotient bit
  assign step  = CmpW'(dat_i.den) << Bit;
  assign rem_x = CmpW'(dat_i.rem);
  assign take  = rem_x >= step;
  assign diff  = rem_x - step;

  always_comb begin
    dat_d = dat_i;
    if (take) begin
      dat_d.rem       = diff[NumWidth-1:0];
      dat_d.quot[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign valid_o = valid_q;
  assign dat_o   = dat_q;

endmodule

`default_nettype wire

[hw/rtl/pabl_skid.sv]
`default_nettype none

module pabl_skid import pabl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  res_t data_i,
  output logic ready_o,
  output logic valid_o,
  output res_t data_o,
  input  logic ready_i
);

  logic out_valid_q, skid_valid_q;
  res_t out_data_q, skid_data_q;
  logic push, pop;

  assign ready_o = !skid_valid_q;
  assign push    = valid_i && !skid_valid_q;
  assign pop     = out_valid_q && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_valid_q) begin
      out_data_q <= skid_valid_q ? skid_data_q : data_i;
    end else if (push) begin
      skid_data_q <= data_i;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

endmodule

`default_nettype wire

[hw/rtl/pixel_area_below_line.sv]
// stages from request acceptance to result valid: classify, square,
//   one cell per quotient bit of the triangle division, output register
// throughput: one request per cycle; the division chain takes a new item every cycle
// the chain stalls as a whole only while the output skid register is full
// reset: asynchronous, active low; clears all valid bits, steep_limit returns to 4104
`default_nettype none

module pixel_area_below_line import pabl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LimWidth-1:0] cfg_wdata_i,
  pabl_req_if.sink            req_i,
  pabl_res_if.source          res_o
);

  logic [LimWidth-1:0] steep_limit_q;
  logic                en;

  logic                cls_valid;
  tag_t                cls_tag;
  logic [HWidth-1:0]   cls_h;
  logic [DenWidth-1:0] cls_den;

  logic                sq_valid_q;
  div_t                sq_dat_q;
  div_t                sq_dat_d;

  logic [QWidth:0]     chain_valid;
  div_t                chain_dat [QWidth+1];

  div_t                last;
  logic [CovWidth-1:0] below;
  res_t                fin;
  res_t                out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steep_limit_q <= SteepLimitRst;
    end else if (cfg_we_i) begin
      steep_limit_q <= cfg_wdata_i;
    end
  end

  assign req_i.ready = en;

  pabl_classify u_classify (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (req_i.valid),
    .func_i        (req_i.func),
    .start_y_i     (req_i.start_y),
    .slope_i       (req_i.slope),
    .steep_limit_i (steep_limit_q),
    .valid_o       (cls_valid),
    .tag_o         (cls_tag),
    .h_o           (cls_h),
    .den_o         (cls_den)
  );

  // squared triangle height
  always_comb begin
    sq_dat_d.tag  = cls_tag;
    sq_dat_d.rem  = NumWidth'(cls_h) * NumWidth'(cls_h);
    sq_dat_d.den  = cls_den;
    sq_dat_d.quot = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
    end else if (en) begin
      sq_valid_q <= cls_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_dat_q <= sq_dat_d;
    end
  end

  assign chain_valid[0] = sq_valid_q;
  assign chain_dat[0]   = sq_dat_q;

  // most significant quotient bit first
  for (genvar k = 0; k < QWidth; k++) begin : g_cell
    pabl_div_cell #(
      .Bit (QWidth - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[k]),
      .dat_i   (chain_dat[k]),
      .valid_o (chain_valid[k+1]),
      .dat_o   (chain_dat[k+1])
    );
  end

  assign last = chain_dat[QWidth];

  always_comb begin
    case (last.tag.mode)
      ModeTriBelow: below = CovWidth'(last.quot);
      ModeTriAbove: below = CovWidth'(One) - CovWidth'(last.quot);
      default:      below = last.tag.direct;
    endcase
    fin.err = last.tag.err;
    if (last.tag.err != ErrNone) begin
      fin.coverage = '0;
    end else if (last.tag.func) begin
      fin.coverage = CovWidth'(One) - below;
    end else begin
      fin.coverage = below;
    end
  end

  pabl_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[QWidth]),
    .data_i  (fin),
    .ready_o (en),
    .valid_o (res_o.valid),
    .data_o  (out_data),
    .ready_i (res_o.ready)
  );

  assign res_o.coverage   = out_data.coverage;
  assign res_o.error_code = out_data.err;

endmodule

`default_nettype wire

[hw/rtl/pabl_checker.sv]
`default_nettype none

module pabl_checker import pabl_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                res_valid_i,
  input logic                res_ready_i,
  input logic [CovWidth-1:0] coverage_i,
  input logic [1:0]          error_code_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(coverage_i)
      && $stable(error_code_i))
    else $error("result changed while stalled");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> error_code_i == ErrNone || error_code_i == ErrSteep
      || error_code_i == ErrGeom)
    else $error("undefined error code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && error_code_i != ErrNone |-> coverage_i == '0)
    else $error("error result with non-zero coverage");

  a_cov_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> coverage_i <= CovWidth'(One))
    else $error("coverage above whole pixel");

endmodule

bind pixel_area_below_line pabl_checker u_pabl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .coverage_i   (res_o.coverage),
  .error_code_i (res_o.error_code)
);

`default_nettype wire
